@@ rtl/core/stsg_pkg.sv @@
// ----------------------------------------------------------------------------
// stsg_pkg
// Shared constants and helpers for the sine table sample generator.
// ----------------------------------------------------------------------------
package stsg_pkg;

   localparam int STSG_TABLE_DEPTH = 4096;
   localparam int STSG_DAC_BITS    = 12;

   // field widths
   localparam int INDEX_W  = 12;
   localparam int AMP_W    = 12;
   localparam int POINTS_W = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int PHASE_W  = 16;
   localparam int SINE_W   = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AMPLITUDE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINTS_PER_PERIOD = 2'd1;

   localparam logic [AMP_W-1:0]    AMP_RESET    = 12'd2048;
   localparam logic [POINTS_W-1:0] POINTS_RESET = 13'd100;

   // pi/2 in Q2.30
   localparam logic [31:0] HALF_PI_Q30 = 32'h6487_ED51;

   // reciprocals ceil(2^41 / d) of the Taylor divisors d = (2k)(2k+1);
   // floor(x * m / 2^41) equals floor(x / d) for any 32-bit x
   localparam int          RECIP_W   = 39;
   localparam logic [63:0] RECIP_ONE = 64'd1 << 41;

   function automatic logic [RECIP_W-1:0] taylor_recip(input logic [3:0] k);
      logic [RECIP_W-1:0] m;
      case (k)
         4'd1:    m = RECIP_W'((RECIP_ONE + 64'd5) / 64'd6);
         4'd2:    m = RECIP_W'((RECIP_ONE + 64'd19) / 64'd20);
         4'd3:    m = RECIP_W'((RECIP_ONE + 64'd41) / 64'd42);
         4'd4:    m = RECIP_W'((RECIP_ONE + 64'd71) / 64'd72);
         4'd5:    m = RECIP_W'((RECIP_ONE + 64'd109) / 64'd110);
         4'd6:    m = RECIP_W'((RECIP_ONE + 64'd155) / 64'd156);
         4'd7:    m = RECIP_W'((RECIP_ONE + 64'd209) / 64'd210);
         4'd8:    m = RECIP_W'((RECIP_ONE + 64'd271) / 64'd272);
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

@@ rtl/core/stsg_ram.sv @@
// ----------------------------------------------------------------------------
// stsg_ram
// Simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module stsg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/sine_table_sample_generator.sv @@
// ----------------------------------------------------------------------------
// sine_table_sample_generator
// Maps a sample index to a DAC code amp*(1+sin(2*pi*index/points)).
// ----------------------------------------------------------------------------
// Accepts one item per cycle unless the pipeline holds or the table fill runs.
// The pipeline holds as a whole on rsp_stall; 16 of its stages are the
// restoring phase divider, one bit each.
// After reset the sine RAM is filled by a serial Taylor engine, with
// req_stall high until it is done.
// Config registers reset to amplitude 2048 and 100 points per period.
// ----------------------------------------------------------------------------
module sine_table_sample_generator
   import stsg_pkg::*;
#(
   parameter int TABLE_DEPTH = STSG_TABLE_DEPTH,
   parameter int DAC_BITS    = STSG_DAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // config
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   // request items
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [INDEX_W-1:0]    req_sample_index,
   // result items
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DAC_BITS-1:0]   rsp_sample_code,
   output logic                  rsp_index_error
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int RW = AW + 2;
   localparam logic [63:0] ANGLE_Q = (64'd1 << 32) / TABLE_DEPTH;
   localparam logic [63:0] ANGLE_R = (64'd1 << 32) % TABLE_DEPTH;
   localparam int NDIV = PHASE_W;
   localparam int RAW_W = 14;
   localparam int CW = (DAC_BITS > RAW_W) ? DAC_BITS : RAW_W;
   localparam logic [CW-1:0] DAC_FULL = CW'((64'd1 << DAC_BITS) - 64'd1);

   // fill sequencer codes
   localparam logic [2:0] FS_PREP     = 3'd0;
   localparam logic [2:0] FS_MUL_LO   = 3'd1;
   localparam logic [2:0] FS_MUL_HI   = 3'd2;
   localparam logic [2:0] FS_MUL_DONE = 3'd3;
   localparam logic [2:0] FS_DIV      = 3'd4;
   localparam logic [2:0] FS_SUM      = 3'd5;
   localparam logic [2:0] FS_WRITE    = 3'd6;
   localparam logic [2:0] FS_DONE     = 3'd7;

   // which product the multiplier is working on
   localparam logic [1:0] MS_THETA = 2'd0;
   localparam logic [1:0] MS_TH2   = 2'd1;
   localparam logic [1:0] MS_TERM  = 2'd2;

   // ------------------------------------------------------------------
   // Config registers
   // ------------------------------------------------------------------
   logic [AMP_W-1:0]    amp_ff;
   logic [POINTS_W-1:0] points_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff    <= AMP_RESET;
         points_ff <= POINTS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_AMPLITUDE:     amp_ff    <= csr_write_data[AMP_W-1:0];
            CSR_POINTS_PER_PERIOD: points_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Table fill engine. Per entry: angle -> theta = r*pi/2, Taylor series
   // to theta^17 in Q2.30 with truncated products, round to Q1.15.
   // One 32x16 multiplier, two passes per product; the constant Taylor
   // divisors are applied as a three-pass reciprocal multiply.
   // ------------------------------------------------------------------
   logic [2:0]    fill_state_ff;
   logic [1:0]    mul_step_ff;
   logic [AW-1:0] fill_addr_ff;
   logic [31:0]   angle_ff;
   logic [AW:0]   angle_rem_ff;
   logic [1:0]    quad_ff;
   logic [31:0]   mul_a_ff;
   logic [31:0]   mul_b_ff;
   logic [63:0]   acc_ff;
   logic [31:0]   theta_ff;
   logic [31:0]   th2_ff;
   logic [31:0]   sum_ff;
   logic [3:0]    k_ff;
   logic [1:0]    rcp_cnt_ff;

   logic          fill_done;
   logic [30:0]   r_in;
   logic [15:0]   mul_b_part;
   logic [47:0]   mul_part;
   logic [31:0]   prod;
   logic [RECIP_W-1:0] recip;
   logic [31:0]   term_q;
   logic [RW-1:0] angle_rsum;
   logic          angle_carry;
   logic [32:0]   mag_rnd;
   logic [17:0]   mag_full;
   logic [14:0]   mag_clip;
   logic [SINE_W-1:0] sine_in;

   assign fill_done = (fill_state_ff == FS_DONE);

   // quadrant fold: odd quadrants run the angle backwards
   assign r_in = angle_ff[30] ? (31'h4000_0000 - {1'b0, angle_ff[29:0]})
                              : {1'b0, angle_ff[29:0]};

   assign recip = taylor_recip(k_ff);

   // multiplier B operand: 16-bit slice of mul_b, or of the reciprocal
   always_comb begin
      if (fill_state_ff == FS_DIV) begin
         case (rcp_cnt_ff)
            2'd0:    mul_b_part = recip[15:0];
            2'd1:    mul_b_part = recip[31:16];
            default: mul_b_part = {9'd0, recip[RECIP_W-1:32]};
         endcase
      end else if (fill_state_ff == FS_MUL_HI) begin
         mul_b_part = mul_b_ff[31:16];
      end else begin
         mul_b_part = mul_b_ff[15:0];
      end
   end

   assign mul_part = 48'(mul_a_ff) * 48'(mul_b_part);
   assign prod     = acc_ff[61:30];
   // acc holds floor(term * recip / 2^32) after the reciprocal passes
   assign term_q   = acc_ff[40:9];

   assign angle_rsum  = RW'(angle_rem_ff) + RW'(ANGLE_R);
   assign angle_carry = (angle_rsum >= RW'(TABLE_DEPTH));

   assign mag_rnd  = {1'b0, sum_ff} + 33'd16384;
   assign mag_full = mag_rnd[32:15];
   assign mag_clip = (mag_full > 18'd32767) ? 15'h7FFF : mag_full[14:0];
   assign sine_in  = quad_ff[1] ? (16'd0 - {1'b0, mag_clip}) : {1'b0, mag_clip};

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_state_ff <= FS_PREP;
         fill_addr_ff  <= '0;
         angle_ff      <= '0;
         angle_rem_ff  <= '0;
      end else begin
         case (fill_state_ff)
            FS_PREP: begin
               fill_state_ff <= FS_MUL_LO;
            end
            FS_MUL_LO:   fill_state_ff <= FS_MUL_HI;
            FS_MUL_HI:   fill_state_ff <= FS_MUL_DONE;
            FS_MUL_DONE: begin
               fill_state_ff <= (mul_step_ff == MS_TERM) ? FS_DIV : FS_MUL_LO;
            end
            FS_DIV: begin
               if (rcp_cnt_ff == 2'd2) begin
                  fill_state_ff <= FS_SUM;
               end
            end
            FS_SUM: begin
               fill_state_ff <= (k_ff == 4'd8) ? FS_WRITE : FS_MUL_LO;
            end
            FS_WRITE: begin
               fill_addr_ff <= fill_addr_ff + AW'(1);
               if (angle_carry) begin
                  angle_rem_ff <= (AW+1)'(angle_rsum - RW'(TABLE_DEPTH));
                  angle_ff     <= angle_ff + 32'(ANGLE_Q) + 32'd1;
               end else begin
                  angle_rem_ff <= (AW+1)'(angle_rsum);
                  angle_ff     <= angle_ff + 32'(ANGLE_Q);
               end
               fill_state_ff <= (fill_addr_ff == AW'(TABLE_DEPTH - 1)) ? FS_DONE : FS_PREP;
            end
            FS_DONE: ;
            default: fill_state_ff <= FS_PREP;
         endcase
      end
   end

   // fill datapath, no reset
   always_ff @(posedge clock) begin
      case (fill_state_ff)
         FS_PREP: begin
            mul_a_ff    <= {1'b0, r_in};
            mul_b_ff    <= HALF_PI_Q30;
            mul_step_ff <= MS_THETA;
            quad_ff     <= angle_ff[31:30];
         end
         FS_MUL_LO: acc_ff <= {16'd0, mul_part};
         FS_MUL_HI: acc_ff <= acc_ff + {mul_part, 16'd0};
         FS_MUL_DONE: begin
            case (mul_step_ff)
               MS_THETA: begin
                  theta_ff    <= prod;
                  mul_a_ff    <= prod;
                  mul_b_ff    <= prod;
                  mul_step_ff <= MS_TH2;
               end
               MS_TH2: begin
                  th2_ff      <= prod;
                  sum_ff      <= theta_ff;
                  mul_a_ff    <= theta_ff;
                  mul_b_ff    <= prod;
                  k_ff        <= 4'd1;
                  mul_step_ff <= MS_TERM;
               end
               default: begin
                  mul_a_ff   <= prod;
                  rcp_cnt_ff <= '0;
               end
            endcase
         end
         FS_DIV: begin
            // low slice first; dropping 16 bits per pass keeps the floor exact
            if (rcp_cnt_ff == 2'd0) begin
               acc_ff <= 64'(mul_part);
            end else begin
               acc_ff <= (acc_ff >> 16) + 64'(mul_part);
            end
            rcp_cnt_ff <= rcp_cnt_ff + 2'd1;
         end
         FS_SUM: begin
            // odd terms subtract (floored at zero), even terms add
            if (k_ff[0]) begin
               sum_ff <= (sum_ff >= term_q) ? sum_ff - term_q : 32'd0;
            end else begin
               sum_ff <= sum_ff + term_q;
            end
            k_ff     <= k_ff + 4'd1;
            mul_a_ff <= term_q;
            mul_b_ff <= th2_ff;
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // Item pipeline: input stage, 16 divider stages, address, RAM read,
   // scale multiply, saturate/output. Whole pipe moves on advance.
   // ------------------------------------------------------------------
   logic advance;
   logic req_accept;

   logic                rsp_valid_ff;
   logic [DAC_BITS-1:0] rsp_code_ff;
   logic                rsp_err_ff;

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !advance || !fill_done;
   assign req_accept = req_valid && !req_stall;

   // divider stages; index 0 is the input register
   logic                pq_valid_ff [0:NDIV];
   logic                pq_err_ff   [0:NDIV];
   logic [POINTS_W-1:0] pq_rem_ff   [0:NDIV];
   logic [PHASE_W-1:0]  pq_quot_ff  [0:NDIV];

   logic [POINTS_W:0]   pq_sh   [1:NDIV];
   logic                pq_bit  [1:NDIV];

   always_comb begin
      for (int j = 1; j <= NDIV; j++) begin
         pq_sh[j]  = {pq_rem_ff[j-1], 1'b0};
         pq_bit[j] = (pq_sh[j] >= {1'b0, points_ff});
      end
   end

   // address, RAM, multiply stages
   logic          sa_valid_ff, sb_valid_ff, sc_valid_ff;
   logic          sa_err_ff,   sb_err_ff,   sc_err_ff;
   logic [AW-1:0] sa_addr_ff;
   logic [32:0]   addr_prod;
   logic [SINE_W-1:0] ram_rd_data;
   logic [16:0]   sine_off;
   logic [28:0]   scale_in;
   logic [28:0]   sc_prod_ff;
   logic [CW-1:0] code_raw;

   assign addr_prod = 33'(pq_quot_ff[NDIV]) * 33'(TABLE_DEPTH);
   assign sine_off  = 17'h0_8000 + {ram_rd_data[SINE_W-1], ram_rd_data};
   assign scale_in  = 29'(amp_ff) * 29'(sine_off);
   assign code_raw  = CW'(sc_prod_ff[28:15]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= NDIV; j++) begin
            pq_valid_ff[j] <= 1'b0;
         end
         sa_valid_ff  <= 1'b0;
         sb_valid_ff  <= 1'b0;
         sc_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         pq_valid_ff[0] <= req_accept;
         for (int j = 1; j <= NDIV; j++) begin
            pq_valid_ff[j] <= pq_valid_ff[j-1];
         end
         sa_valid_ff  <= pq_valid_ff[NDIV];
         sb_valid_ff  <= sa_valid_ff;
         sc_valid_ff  <= sb_valid_ff;
         rsp_valid_ff <= sc_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pq_err_ff[0]  <= ({1'b0, req_sample_index} >= points_ff);
         pq_rem_ff[0]  <= {1'b0, req_sample_index};
         pq_quot_ff[0] <= '0;
         for (int j = 1; j <= NDIV; j++) begin
            pq_err_ff[j]  <= pq_err_ff[j-1];
            pq_rem_ff[j]  <= pq_bit[j] ? POINTS_W'(pq_sh[j] - {1'b0, points_ff})
                                       : pq_sh[j][POINTS_W-1:0];
            pq_quot_ff[j] <= {pq_quot_ff[j-1][PHASE_W-2:0], pq_bit[j]};
         end
         sa_err_ff  <= pq_err_ff[NDIV];
         sa_addr_ff <= addr_prod[AW+15:16];
         sb_err_ff  <= sa_err_ff;
         sc_err_ff  <= sb_err_ff;
         sc_prod_ff <= scale_in;
         rsp_err_ff <= sc_err_ff;
         if (sc_err_ff) begin
            rsp_code_ff <= '0;
         end else if (code_raw > DAC_FULL) begin
            rsp_code_ff <= DAC_FULL[DAC_BITS-1:0];
         end else begin
            rsp_code_ff <= code_raw[DAC_BITS-1:0];
         end
      end
   end

   stsg_ram #(
      .WIDTH(SINE_W),
      .DEPTH(TABLE_DEPTH)
   ) u_sine_ram (
      .clock  (clock),
      .wr_en  (fill_state_ff == FS_WRITE),
      .wr_addr(fill_addr_ff),
      .wr_data(sine_in),
      .rd_en  (advance),
      .rd_addr(sa_addr_ff),
      .rd_data(ram_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_code = rsp_code_ff;
   assign rsp_index_error = rsp_err_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   a_err_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> (rsp_code_ff == '0))
      else $error("error item with nonzero code");

   a_no_result_during_fill: assert property (@(posedge clock) disable iff (reset)
      (pq_valid_ff[0] || sa_valid_ff || rsp_valid_ff) |-> fill_done)
      else $error("item in pipe while table fill runs");

   a_addr_in_range: assert property (@(posedge clock) disable iff (reset)
      sa_valid_ff |-> (32'(sa_addr_ff) < 32'(TABLE_DEPTH)))
      else $error("table address out of range");

   a_fill_write_order: assert property (@(posedge clock) disable iff (reset)
      (fill_state_ff == FS_WRITE) |=> (fill_addr_ff == $past(fill_addr_ff) + AW'(1)))
      else $error("fill address skipped");

endmodule

@@ verif/sine_table_sample_generator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sine_table_sample_generator_tb
// Checks each DAC code and range flag against a local fixed-point sine model.
// A short directed table at reset settings comes first. Random items then run
// over several amplitude / point-count settings, with random stalls on both
// sides and one long output hold-off.
// ----------------------------------------------------------------------------
module sine_table_sample_generator_tb
   import stsg_pkg::*;
;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd2;   // no register here
   localparam int DRAIN_CYCLES = 30;                      // longer than the item pipeline

   typedef struct packed {
      logic [11:0] code;
      logic        err;
   } dac_sample_type;

   typedef struct {
      logic [INDEX_W-1:0] idx;
      bit                 known;    // expected value typed in below
      logic [11:0]        code;
      logic               err;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [INDEX_W-1:0]    req_sample_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b1;
   logic [11:0]           rsp_sample_code;
   logic                  rsp_index_error;

   // local copy of the config registers
   logic [AMP_W-1:0]    amp_cfg = AMP_RESET;
   logic [POINTS_W-1:0] pts_cfg = POINTS_RESET;

   dac_sample_type expected_samples[$];
   int  mismatches = 0;
   bit  tx_idle_on = 1'b1;
   bit  rx_idle_on = 1'b1;
   bit  holdoff_req = 1'b0;
   int  holdoff_left = 0;

   sine_table_sample_generator dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_index (req_sample_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_code  (rsp_sample_code),
      .rsp_index_error  (rsp_index_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Fixed-point sine path: index -> 16-bit phase -> table entry -> 0.32 turn
   // -> Taylor series on the first quadrant (Q2.30) -> Q1.15 -> DAC code.
   function automatic dac_sample_type predict_sample(logic [INDEX_W-1:0] idx);
      logic [63:0] phase, entry, angle, quad, r, theta, th2, term, acc, mag, code;
      logic signed [31:0] s;
      dac_sample_type res;
      if (64'(idx) >= 64'(pts_cfg)) begin
         res.code = '0;
         res.err  = 1'b1;
         return res;
      end
      phase = ((64'(idx) << 16) / 64'(pts_cfg)) & 64'hFFFF;
      entry = (phase * 64'(STSG_TABLE_DEPTH)) >> 16;
      angle = (entry << 32) / 64'(STSG_TABLE_DEPTH);
      quad  = (angle >> 30) & 64'd3;
      r     = angle & 64'h3FFF_FFFF;
      if (quad[0])
         r = 64'h4000_0000 - r;                  // mirror odd quadrants
      theta = (r * 64'(HALF_PI_Q30)) >> 30;
      th2   = (theta * theta) >> 30;
      term  = theta;
      acc   = theta;
      for (int k = 1; k <= 8; k++) begin
         term = (term * th2) >> 30;
         term = term / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1)
            acc = (acc >= term) ? acc - term : 64'd0;
         else
            acc = acc + term;
      end
      mag = (acc + 64'd16384) >> 15;             // round half up to Q1.15
      if (mag > 64'd32767)
         mag = 64'd32767;
      s = (quad >= 64'd2) ? -32'(mag) : 32'(mag);
      code = (64'(amp_cfg) * 64'(32768 + s)) >> 15;
      if (code > 64'd4095)
         code = 64'd4095;                        // clip, flag stays low
      res.code = code[11:0];
      res.err  = 1'b0;
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d, want %0d (t=%0t)", what, got, want, $time);
      mismatches++;
   endtask

   // Result side: check, then pick next stall (random, or the long hold-off).
   initial begin
      dac_sample_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("unexpected item", rsp_sample_code, -1);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample_code !== want.code)
                  report_mismatch("sample_code", rsp_sample_code, want.code);
               if (rsp_index_error !== want.err)
                  report_mismatch("index_error", rsp_index_error, want.err);
            end
         end
         if (holdoff_req) begin
            holdoff_req  = 1'b0;
            holdoff_left = 300;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= rx_idle_on && ($urandom_range(99) < 36);
         end
      end
   end

   // One item: optional idle cycles, then offer until taken. Valid stays
   // high into the next call so back-to-back items need no re-raise.
   task automatic send_index(logic [INDEX_W-1:0] idx, bit known = 1'b0,
                             logic [11:0] code = '0, logic err = 1'b0);
      dac_sample_type want;
      while (tx_idle_on && ($urandom_range(99) < 36)) begin
         req_valid <= 1'b0;
         req_sample_index <= INDEX_W'($urandom);
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_index <= idx;
      do @(posedge clock); while (req_stall);
      want = predict_sample(idx);
      if (known) begin
         want.code = code;
         want.err  = err;
      end
      expected_samples.push_back(want);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes both registers plus an ignored index, then updates the model.
   task automatic set_config(logic [CSR_DATA_W-1:0] amp, logic [CSR_DATA_W-1:0] pts);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_MAX_AMPLITUDE;
      csr_write_data   <= amp;
      @(posedge clock);
      csr_index        <= CSR_POINTS_PER_PERIOD;
      csr_write_data   <= pts;
      @(posedge clock);
      csr_index        <= CSR_UNUSED;
      csr_write_data   <= CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      amp_cfg = amp[AMP_W-1:0];
      pts_cfg = pts;
   endtask

   // Mostly in-range indexes, some anywhere in the field.
   task automatic random_items(int count);
      logic [INDEX_W-1:0] idx;
      for (int i = 0; i < count; i++) begin
         if (pts_cfg != 0 && $urandom_range(99) < 80)
            idx = INDEX_W'($urandom_range((pts_cfg > 4096 ? 4096 : pts_cfg) - 1));
         else
            idx = INDEX_W'($urandom);
         send_index(idx);
      end
   endtask

   directed_row_type directed[] = '{
      '{12'd0,    1, 12'd2048, 1'b0},   // zero phase: mid scale
      '{12'd25,   1, 12'd4095, 1'b0},   // peak: clipped at full scale
      '{12'd50,   1, 12'd2048, 1'b0},   // half turn
      '{12'd75,   1, 12'd0,    1'b0},   // trough
      '{12'd99,   0, 12'd0,    1'b0},   // last point of the period
      '{12'd100,  1, 12'd0,    1'b1},   // first index out of range
      '{12'd4095, 1, 12'd0,    1'b1},   // top of the field
      '{12'd2048, 1, 12'd0,    1'b1},
      '{12'd1,    0, 12'd0,    1'b0},
      '{12'd12,   0, 12'd0,    1'b0},
      '{12'd13,   0, 12'd0,    1'b0},
      '{12'd24,   0, 12'd0,    1'b0},
      '{12'd26,   0, 12'd0,    1'b0},
      '{12'd37,   0, 12'd0,    1'b0},
      '{12'd49,   0, 12'd0,    1'b0},
      '{12'd51,   0, 12'd0,    1'b0},
      '{12'd63,   0, 12'd0,    1'b0},
      '{12'd74,   0, 12'd0,    1'b0},
      '{12'd76,   0, 12'd0,    1'b0},
      '{12'd88,   0, 12'd0,    1'b0}
   };

   initial begin
      int guard;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings, directed rows; the table fill holds req_stall first
      foreach (directed[i])
         send_index(directed[i].idx, directed[i].known, directed[i].code,
                    directed[i].err);
      wait_drained();

      // extremes of both registers
      set_config(13'd1, 13'd1);               // one point, least nonzero amplitude
      for (int i = 0; i < 8; i++)
         send_index(i[0] ? 12'd0 : INDEX_W'($urandom));
      wait_drained();
      set_config(13'd4095, 13'd4096);         // deep saturation, full period
      random_items(220);
      wait_drained();
      set_config(13'd0, 13'd0);               // zero amplitude, zero points
      random_items(60);
      wait_drained();

      // no idling at all, then the long output hold-off
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      set_config(13'd2048, 13'd4096);
      holdoff_req = 1'b1;
      random_items(300);
      wait_drained();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;

      set_config(13'd1000, 13'd8191);         // points above the field
      random_items(150);
      wait_drained();
      set_config(13'd3000, 13'd37);
      random_items(200);
      wait_drained();
      set_config(13'd4095, 13'd0);            // all indexes out of range
      random_items(40);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         set_config(CSR_DATA_W'($urandom_range(1, 4095)),
                    (p % 2) ? CSR_DATA_W'($urandom_range(1, 16))
                            : CSR_DATA_W'($urandom_range(1, 8191)));
         random_items(120);
         wait_drained();
      end

      guard = 0;
      while (expected_samples.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      if (expected_samples.size() != 0)
         report_mismatch("items never returned", 0, expected_samples.size());
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // timeout covers the table fill after reset and many times the run
   initial begin
      #40_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/stsg_pkg.sv
rtl/core/stsg_ram.sv
rtl/core/sine_table_sample_generator.sv
verif/sine_table_sample_generator_tb.sv
